@@ src/svpwm_pkg.sv @@
// shared types and constants for the three-phase svpwm duty generator
package svpwm_pkg;

  localparam int REF_W  = 16;
  localparam int WREF_W = 18;
  localparam int DUTY_W = 14;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 14'd10000;

  // q30 odd taylor coefficients of sin(pi/2*u)
  localparam logic [63:0] K1  = 64'd1686629713;
  localparam logic [63:0] K3  = 64'd693598668;
  localparam logic [63:0] K5  = 64'd85569305;
  localparam logic [63:0] K7  = 64'd5026995;
  localparam logic [63:0] K9  = 64'd172267;
  localparam logic [63:0] K11 = 64'd3864;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENABLE       = 8'd0,
    CFG_USE_EXTERNAL = 8'd1,
    CFG_MOD_INDEX    = 8'd2,
    CFG_PHASE_STEP   = 8'd3
  } cfg_reg_t;

  typedef logic signed [REF_W-1:0]  ext_ref_t;
  typedef logic signed [WREF_W-1:0] wide_ref_t;

  typedef struct packed {
    logic             adv;
    logic             use_ext;
    logic [REF_W-1:0] mod_index;
  } lane_ctl_t;

  typedef struct packed {
    logic adv;
    logic en;
  } merge_ctl_t;

endpackage

@@ src/svpwm_lane.sv @@
// one phase lane: quarter-wave sine lookup and modulation index scaling, or an external reference
module svpwm_lane #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                        clk,
  input  svpwm_pkg::lane_ctl_t        ctl,
  input  logic [SINE_TABLE_BITS-1:0]  idx,
  input  svpwm_pkg::ext_ref_t         ext_ref,
  output svpwm_pkg::wide_ref_t        ref_out
);
  import svpwm_pkg::*;

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int KW = SINE_TABLE_BITS - 1;

  typedef logic [14:0] qtab_t [QUARTER+1];

  function automatic qtab_t build_qtab();
    qtab_t t;
    logic [63:0] u;
    logic [63:0] s;
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] a;
    for (int k = 0; k <= QUARTER; k++) begin
      u = 64'(k) << (30 - (SINE_TABLE_BITS - 2));
      s = (u * u) >> 30;
      p = K11;
      p = K9 - ((s * p) >> 30);
      p = K7 - ((s * p) >> 30);
      p = K5 - ((s * p) >> 30);
      p = K3 - ((s * p) >> 30);
      p = K1 - ((s * p) >> 30);
      r = (u * p) >> 30;
      a = (r * 64'd32767 + 64'd536870912) >> 30;
      if (a > 64'd32767) begin
        a = 64'd32767;
      end
      t[k] = a[14:0];
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [1:0]    quad;
  logic [KW-1:0] k;
  logic [KW-1:0] kk;

  logic [14:0]  mag;
  logic         neg;
  logic         use_ext1;
  ext_ref_t     ext1;

  logic [31:0]  prod;
  logic [15:0]  m;
  wide_ref_t    ref_next;

  // odd quadrants run the quarter wave backwards
  always_comb begin
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    k    = {1'b0, idx[SINE_TABLE_BITS-3:0]};
    kk   = quad[0] ? (KW'(QUARTER) - k) : k;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      mag      <= QTAB[kk];
      neg      <= quad[1];
      use_ext1 <= ctl.use_ext;
      ext1     <= ext_ref;
    end
  end

  // round half away from zero on the magnitude
  always_comb begin
    prod = 32'(mag) * 32'(ctl.mod_index) + 32'd16384;
    m    = prod[30:15];
    if (use_ext1) begin
      ref_next = WREF_W'(ext1);
    end else if (neg) begin
      ref_next = -$signed({2'b00, m});
    end else begin
      ref_next = $signed({2'b00, m});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      ref_out <= ref_next;
    end
  end

endmodule

@@ src/svpwm_merge.sv @@
// min/max common-mode removal and duty mapping over the three lanes
module svpwm_merge (
  input  logic                         clk,
  input  svpwm_pkg::merge_ctl_t        ctl,
  input  svpwm_pkg::wide_ref_t         ref_in [3],
  output logic [svpwm_pkg::DUTY_W-1:0] duty [3],
  output logic                         outputs_on
);
  import svpwm_pkg::*;

  wide_ref_t          r1 [3];
  wide_ref_t          mx;
  wide_ref_t          mn;
  wide_ref_t          mx_next;
  wide_ref_t          mn_next;
  logic               en1;
  logic               en2;
  logic signed [19:0] d [3];
  logic signed [33:0] n_next [3];
  logic signed [33:0] n [3];
  logic signed [16:0] q [3];

  always_comb begin
    mx_next = ref_in[0];
    mn_next = ref_in[0];
    for (int i = 1; i < 3; i++) begin
      if (ref_in[i] > mx_next) begin
        mx_next = ref_in[i];
      end
      if (ref_in[i] < mn_next) begin
        mn_next = ref_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      r1  <= ref_in;
      mx  <= mx_next;
      mn  <= mn_next;
      en1 <= ctl.en;
    end
  end

  // duty = ((d + 1.0) * 10000 + half lsb) / 2^17
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i]      = (20'(r1[i]) <<< 1) - 20'(mx) - 20'(mn);
      n_next[i] = (34'(d[i]) + 34'sd65536) * 34'sd10000 + 34'sd65536;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      n   <= n_next;
      en2 <= en1;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = 17'(n[i] >>> 17);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      outputs_on <= en2;
      for (int i = 0; i < 3; i++) begin
        if (!en2 || n[i][33]) begin
          duty[i] <= '0;
        end else if (q[i] > 17'sd10000) begin
          duty[i] <= DUTY_MAX;
        end else begin
          duty[i] <= q[i][DUTY_W-1:0];
        end
      end
    end
  end

endmodule

@@ src/three_phase_svpwm_duty_generator.sv @@
// top level: phase accumulator, handshake, configuration and lane/merge pipeline
//
// Each input word is one control tick and yields exactly one output word. The
// datapath is a six-stage pipeline (phase/index register, sine table read,
// amplitude scaling, min/max, centering and duty multiply, saturation into the
// output register) with three lanes for U, V and W, so a new word is taken
// every cycle unless the output stalls. The whole pipe holds only while the
// output word waits for m_tready. Configuration writes are always accepted and
// take effect for words accepted afterward, but a mod index write also reaches
// words not yet scaled; write them while the pipe is empty. When enable is 0
// the phase is cleared and the word carries zero duties with outputs_on low.
module three_phase_svpwm_duty_generator #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // ext_u, ext_v, ext_w
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // duty_u, duty_v, duty_w, zero pad
  output logic        m_tuser,   // outputs_on
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [svpwm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [svpwm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import svpwm_pkg::*;

  localparam logic [63:0] THIRD64 = (64'd1 << PHASE_BITS) / 64'd3;
  localparam logic [PHASE_BITS-1:0] THIRD = THIRD64[PHASE_BITS-1:0];
  localparam int STAGES = 6;

  logic                  enable;
  logic                  use_external;
  logic [REF_W-1:0]      mod_gain;
  logic [31:0]           phase_step;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_acc_next;
  logic [PHASE_BITS-1:0] ph [3];

  logic [STAGES-1:0]     valid;
  logic                  adv;
  logic                  accept;

  logic [SINE_TABLE_BITS-1:0] idx [3];
  ext_ref_t              ext1 [3];
  logic                  use_ext1;
  logic                  en1;
  logic                  en2;
  logic                  en3;

  lane_ctl_t             lane_ctl;
  merge_ctl_t            merge_ctl;
  wide_ref_t             refs [3];
  logic [DUTY_W-1:0]     duty [3];
  logic                  outputs_on;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      use_external <= 1'b0;
      mod_gain     <= '0;
      phase_step   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE:       enable       <= cfg_data[0];
        CFG_USE_EXTERNAL: use_external <= cfg_data[0];
        CFG_MOD_INDEX:    mod_gain     <= cfg_data[REF_W-1:0];
        CFG_PHASE_STEP:   phase_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  // the whole pipe moves unless the output word is stalled
  assign adv      = !valid[STAGES-1] || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign m_tvalid = valid[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[STAGES-2:0], s_tvalid};
    end
  end

  always_comb begin
    phase_acc_next = enable ? (phase_acc + PHASE_BITS'(phase_step)) : '0;
    ph[0] = phase_acc_next;
    ph[1] = phase_acc_next - THIRD;
    ph[2] = phase_acc_next + THIRD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (accept) begin
      phase_acc <= phase_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        idx[i]  <= ph[i][PHASE_BITS-1 -: SINE_TABLE_BITS];
        ext1[i] <= s_tdata[i*REF_W +: REF_W];
      end
      use_ext1 <= use_external;
      en1      <= enable;
      en2      <= en1;
      en3      <= en2;
    end
  end

  always_comb begin
    lane_ctl.adv       = adv;
    lane_ctl.use_ext   = use_ext1;
    lane_ctl.mod_index = mod_gain;
    merge_ctl.adv      = adv;
    merge_ctl.en       = en3;
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    svpwm_lane #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .idx     (idx[g]),
      .ext_ref (ext1[g]),
      .ref_out (refs[g])
    );
  end

  svpwm_merge u_merge (
    .clk        (clk),
    .ctl        (merge_ctl),
    .ref_in     (refs),
    .duty       (duty),
    .outputs_on (outputs_on)
  );

  assign m_tdata = {6'd0, duty[2], duty[1], duty[0]};
  assign m_tuser = outputs_on;

endmodule

@@ test/tb_three_phase_svpwm_duty_generator.sv @@
// testbench for the three-phase svpwm duty generator: own duty predictor, random stream stalls
module tb_three_phase_svpwm_duty_generator;
  import svpwm_pkg::*;

  localparam int SINE_BITS    = 10;
  localparam int PH_BITS      = 32;
  localparam int PIPE_LATENCY = 6;
  localparam int QUARTER      = 1 << (SINE_BITS - 2);
  localparam logic [PH_BITS-1:0] THIRD_TURN = PH_BITS'((64'd1 << PH_BITS) / 3);
  localparam logic [CFG_INDEX_W-1:0] CFG_NONE_LO = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONE_HI = 8'hFF;
  localparam int PRINT_CAP    = 30;

  typedef struct packed {
    ext_ref_t w;
    ext_ref_t v;
    ext_ref_t u;
  } tick_t;

  typedef struct packed {
    logic              on;
    logic [DUTY_W-1:0] w;
    logic [DUTY_W-1:0] v;
    logic [DUTY_W-1:0] u;
  } duty_set_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  three_phase_svpwm_duty_generator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor copy of registers and phase
  logic               cur_enable = 1'b0;
  logic               cur_ext    = 1'b0;
  logic [15:0]        cur_mod    = '0;
  logic [PH_BITS-1:0] cur_step   = '0;
  logic [PH_BITS-1:0] phase_acc  = '0;

  tick_t     tick_q[$];
  duty_set_t duty_q[$];

  bit in_accepted  = 1'b0;
  bit out_accepted = 1'b0;
  bit in_calm      = 1'b0;
  bit out_calm     = 1'b0;
  int in_gap       = 0;
  int out_stall    = 0;

  int n_errors = 0;
  int n_ticks = 0, n_off = 0, n_sine = 0, n_ext = 0, n_clipped = 0, n_settings = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  function automatic int draw_wait(input bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 18);
      1: return $urandom_range(0, 2);
      default: return 0;
    endcase
  endfunction

  // q1.15 sine of a quarter-wave point, k in 0..QUARTER
  function automatic longint quarter_sine(input int k);
    longint unsigned u, s, p, r, a;
    u = longint'(k) << (30 - (SINE_BITS - 2));
    s = (u * u) >> 30;
    p = K11;
    p = K9 - ((s * p) >> 30);
    p = K7 - ((s * p) >> 30);
    p = K5 - ((s * p) >> 30);
    p = K3 - ((s * p) >> 30);
    p = K1 - ((s * p) >> 30);
    r = (u * p) >> 30;
    a = (r * 64'd32767 + 64'd536870912) >> 30;
    if (a > 64'd32767) a = 64'd32767;
    return longint'(a);
  endfunction

  function automatic longint sine_at(input logic [PH_BITS-1:0] ph);
    int idx, quad, k;
    longint val;
    idx  = int'(ph >> (PH_BITS - SINE_BITS));
    quad = (idx >> (SINE_BITS - 2)) & 3;
    k    = idx & (QUARTER - 1);
    val  = quarter_sine((quad & 1) ? QUARTER - k : k);
    return (quad & 2) ? -val : val;
  endfunction

  // round half away from zero, kept wide
  function automatic longint scale_sine(input longint sn);
    longint unsigned mag, m;
    mag = (sn < 0) ? longint'(-sn) : longint'(sn);
    m = (mag * cur_mod + 64'd16384) >> 15;
    return (sn < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [DUTY_W-1:0] centered_to_duty(input longint d);
    longint n, q;
    n = (d + 65536) * 10000 + 65536;
    if (n < 0) return '0;
    q = n / 131072;
    if (q > 10000) q = 10000;
    return DUTY_W'(q);
  endfunction

  function automatic duty_set_t predict_duties(input logic [47:0] word);
    duty_set_t res;
    longint ref_v[3];
    longint hi, lo;
    logic [DUTY_W-1:0] d[3];
    res = '0;
    n_ticks++;
    if (!cur_enable) begin
      phase_acc = '0;
      n_off++;
      return res;
    end
    phase_acc = phase_acc + cur_step;
    if (cur_ext) begin
      ref_v[0] = longint'($signed(word[15:0]));
      ref_v[1] = longint'($signed(word[31:16]));
      ref_v[2] = longint'($signed(word[47:32]));
      n_ext++;
    end else begin
      ref_v[0] = scale_sine(sine_at(phase_acc));
      ref_v[1] = scale_sine(sine_at(phase_acc - THIRD_TURN));
      ref_v[2] = scale_sine(sine_at(phase_acc + THIRD_TURN));
      n_sine++;
    end
    hi = ref_v[0];
    lo = ref_v[0];
    for (int i = 1; i < 3; i++) begin
      if (ref_v[i] > hi) hi = ref_v[i];
      if (ref_v[i] < lo) lo = ref_v[i];
    end
    for (int i = 0; i < 3; i++) begin
      d[i] = centered_to_duty(2 * ref_v[i] - hi - lo);
      if (d[i] == 0 || d[i] == DUTY_MAX) n_clipped++;
    end
    res.u  = d[0];
    res.v  = d[1];
    res.w  = d[2];
    res.on = 1'b1;
    return res;
  endfunction

  // input side: predict on every accepted word
  always @(posedge clk) begin
    in_accepted = !rst && s_tvalid && s_tready;
    if (in_accepted) duty_q.push_back(predict_duties(s_tdata));
  end

  always @(negedge clk) begin : tick_driver
    tick_t next_tick;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_accepted) begin
      if (in_gap > 0 || tick_q.size() == 0) begin
        s_tvalid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        next_tick = tick_q.pop_front();
        s_tdata  <= {next_tick.w, next_tick.u[0] ? next_tick.v : next_tick.v, next_tick.u};
        s_tvalid <= 1'b1;
        in_gap = draw_wait(in_calm);
      end
    end
  end

  // output side: check every accepted word against the oldest prediction
  always @(posedge clk) begin : duty_checker
    duty_set_t want;
    out_accepted = !rst && m_tvalid && m_tready;
    if (out_accepted) begin
      if (duty_q.size() == 0) begin
        report_mismatch("unexpected word", longint'(m_tdata[41:0]), longint'(0));
      end else begin
        want = duty_q.pop_front();
        if (m_tdata[13:0] != want.u)
          report_mismatch("duty_u", longint'(m_tdata[13:0]), longint'(want.u));
        if (m_tdata[27:14] != want.v)
          report_mismatch("duty_v", longint'(m_tdata[27:14]), longint'(want.v));
        if (m_tdata[41:28] != want.w)
          report_mismatch("duty_w", longint'(m_tdata[41:28]), longint'(want.w));
        if (m_tdata[47:42] != '0)
          report_mismatch("pad", longint'(m_tdata[47:42]), longint'(0));
        if (m_tuser !== want.on)
          report_mismatch("outputs_on", longint'(m_tuser), longint'(want.on));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_accepted) out_stall = draw_wait(out_calm);
      if (out_stall > 0) begin
        m_tready <= 1'b0;
        out_stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ENABLE:       cur_enable = val[0];
      CFG_USE_EXTERNAL: cur_ext    = val[0];
      CFG_MOD_INDEX:    cur_mod    = val[15:0];
      CFG_PHASE_STEP:   cur_step   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper bits of the narrow registers carry noise
  task automatic set_regs(input bit en, input bit ext, input logic [15:0] mi,
                          input logic [PH_BITS-1:0] step);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom;
    write_reg(CFG_ENABLE, {noise[31:1], en});
    noise = $urandom;
    write_reg(CFG_USE_EXTERNAL, {noise[31:1], ext});
    noise = $urandom;
    write_reg(CFG_MOD_INDEX, {noise[31:16], mi});
    write_reg(CFG_PHASE_STEP, step);
    n_settings++;
  endtask

  task automatic push_tick(input ext_ref_t u, input ext_ref_t v, input ext_ref_t w);
    tick_t t;
    t.u = u;
    t.v = v;
    t.w = w;
    tick_q.push_back(t);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (tick_q.size() != 0 || s_tvalid || duty_q.size() != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  function automatic ext_ref_t pick_ref();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return ext_ref_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    bit                 en, ext;
    logic [15:0]        mi;
    logic [PH_BITS-1:0] step;
    int                 n_items;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // disabled, with masked register values and writes to unused indexes
    in_calm  = 1'b1;
    out_calm = 1'b1;
    write_reg(CFG_ENABLE, 32'hFFFF_FFFE);
    write_reg(CFG_USE_EXTERNAL, 32'hFFFF_FFFF);
    write_reg(CFG_MOD_INDEX, 32'hFFFF_8000);
    write_reg(CFG_PHASE_STEP, '0);
    write_reg(CFG_NONE_LO, 32'hFFFF_FFFF);
    write_reg(CFG_NONE_HI, 32'hFFFF_FFFF);
    push_tick(16'sh7FFF, 16'sh8000, 16'sh1234);
    push_tick(16'sh8000, 16'sh7FFF, 16'shFFFF);
    wait_idle();

    // external references at the field extremes, phase running underneath
    write_reg(CFG_ENABLE, 32'hFFFF_FFFF);
    write_reg(CFG_PHASE_STEP, 32'h1234_5679);
    push_tick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_tick(16'sh8000, 16'sh8000, 16'sh8000);
    push_tick(16'sh7FFF, 16'sh8000, 16'sh0000);
    push_tick(16'sh8000, 16'sh7FFF, 16'sh8000);
    push_tick(16'sh0000, 16'sh0000, 16'sh0000);
    push_tick(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    push_tick(16'shFFFF, 16'sh0001, 16'sh4000);
    wait_idle();

    // internal sine, over-range amplitude, phase carried over from external mode
    in_calm  = 1'b0;
    out_calm = 1'b0;
    write_reg(CFG_USE_EXTERNAL, 32'h0000_0000);
    write_reg(CFG_MOD_INDEX, 32'h0000_FFFF);
    repeat (6) push_tick(pick_ref(), pick_ref(), pick_ref());
    wait_idle();
    // quarter-turn steps land on the quadrant edges
    write_reg(CFG_MOD_INDEX, 32'h0000_8000);
    write_reg(CFG_PHASE_STEP, 32'h4000_0000);
    repeat (4) push_tick(pick_ref(), pick_ref(), pick_ref());
    wait_idle();
    write_reg(CFG_MOD_INDEX, 32'h0000_0000);
    write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    repeat (2) push_tick(pick_ref(), pick_ref(), pick_ref());
    wait_idle();

    // random settings, mostly enabled
    for (int ph = 0; ph < 14; ph++) begin
      en  = ($urandom_range(0, 9) != 0);
      ext = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: mi = 16'h0000;
        1: mi = 16'hFFFF;
        2: mi = 16'h8000;
        default: mi = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: step = '0;
        1: step = '1;
        2: step = PH_BITS'($urandom_range(1, 1 << 20));
        default: step = $urandom;
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(CFG_NONE_LO + 8'($urandom_range(0, 200)), $urandom);
      set_regs(en, ext, mi, step);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(95, 125);
      repeat (n_items) push_tick(pick_ref(), pick_ref(), pick_ref());
      wait_idle();
    end

    repeat (PIPE_LATENCY + 4) @(posedge clk);
    $display("ran %0d ticks over %0d random register settings: %0d disabled, %0d sine, %0d external",
             n_ticks, n_settings, n_off, n_sine, n_ext);
    $display("%0d phase duties clipped to an end of the range, %0d mismatches",
             n_clipped, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/svpwm_pkg.sv
src/svpwm_lane.sv
src/svpwm_merge.sv
src/three_phase_svpwm_duty_generator.sv
test/tb_three_phase_svpwm_duty_generator.sv
